// ===== src/dxt_pkg.sv =====
package dxt_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [12:0] width;
    logic [12:0] height;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       fmt;
    logic             four;
    rgb_t [3:0]       pal;
    logic [7:0][7:0]  atab;
    logic [31:0]      cidx;
    logic [63:0]      ablk;
    logic [9:0]       col;
    logic [9:0]       row;
    logic [15:0]      mask;
  } job_t;

endpackage

// ===== src/dxt_front.sv =====
module dxt_front #(
  parameter int MAX_DIM = dxt_pkg::MAX_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dxt_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [63:0]        color_block_i,
  input  logic [63:0]        alpha_block_i,
  input  logic [9:0]         block_col_i,
  input  logic [9:0]         block_row_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output dxt_pkg::job_t      job_o
);

  localparam logic [28:0] W5_K = 29'd8625630;
  localparam logic [28:0] W6_K = 29'd4244475;
  localparam int DIV3_K = 683;
  localparam int DIV7_K = 2341;
  localparam int DIV5_K = 3277;
  localparam logic [12:0] DIM_MAX = 13'(MAX_DIM);

  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [28:0] p;
    p = 29'(v) * W5_K;
    return p[27:20];
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [28:0] p;
    p = 29'(v) * W6_K;
    return p[27:20];
  endfunction

  function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
    logic [19:0] p;
    p = 20'(a) * 20'(2 * DIV3_K) + 20'(b) * 20'(DIV3_K);
    return p[18:11];
  endfunction

  logic             s1_valid_q, s1_valid_d;
  logic             accept;
  logic [1:0]       fmt_q;
  logic             four_q;
  dxt_pkg::rgb_t    e0_q, e1_q;
  logic [31:0]      cidx_q;
  logic [63:0]      ablk_q;
  logic [9:0]       col_q, row_q;
  logic [15:0]      mask_q, mask_d;
  logic             four_d;
  logic [12:0]      w_eff, h_eff;
  logic [3:0]       col_ok, row_ok;
  logic [15:0]      c0, c1;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || push_ready_i;
  assign push_o     = s1_valid_q && push_ready_i;

  assign c0 = color_block_i[15:0];
  assign c1 = color_block_i[31:16];
  assign w_eff = (cfg_i.width > DIM_MAX) ? DIM_MAX : cfg_i.width;
  assign h_eff = (cfg_i.height > DIM_MAX) ? DIM_MAX : cfg_i.height;

  always_comb begin
    four_d = (cfg_i.fmt == dxt_pkg::FMT_DXT3) || (cfg_i.fmt == dxt_pkg::FMT_DXT5) || (c0 > c1);
    for (int j = 0; j < 4; j++) begin
      col_ok[j] = {1'b0, block_col_i, 2'(j)} < w_eff;
      row_ok[j] = {1'b0, block_row_i, 2'(j)} < h_eff;
    end
    for (int k = 0; k < 16; k++) begin
      mask_d[k] = col_ok[k % 4] && row_ok[k / 4];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fmt_q   <= cfg_i.fmt;
      four_q  <= four_d;
      e0_q.r  <= widen5(c0[15:11]);
      e0_q.g  <= widen6(c0[10:5]);
      e0_q.b  <= widen5(c0[4:0]);
      e1_q.r  <= widen5(c1[15:11]);
      e1_q.g  <= widen6(c1[10:5]);
      e1_q.b  <= widen5(c1[4:0]);
      cidx_q  <= color_block_i[63:32];
      ablk_q  <= alpha_block_i;
      col_q   <= block_col_i;
      row_q   <= block_row_i;
      mask_q  <= mask_d;
    end
  end

  // palette from the widened endpoints, alpha table from the alpha endpoints
  logic [7:0]  a0, a1;
  logic [8:0]  sum_r, sum_g, sum_b;
  logic [21:0] ap;

  assign a0 = ablk_q[7:0];
  assign a1 = ablk_q[15:8];
  assign sum_r = {1'b0, e0_q.r} + {1'b0, e1_q.r};
  assign sum_g = {1'b0, e0_q.g} + {1'b0, e1_q.g};
  assign sum_b = {1'b0, e0_q.b} + {1'b0, e1_q.b};

  always_comb begin
    ap = '0;
    job_o.fmt    = fmt_q;
    job_o.four   = four_q;
    job_o.pal[0] = e0_q;
    job_o.pal[1] = e1_q;
    if (four_q) begin
      job_o.pal[2].r = third(e0_q.r, e1_q.r);
      job_o.pal[2].g = third(e0_q.g, e1_q.g);
      job_o.pal[2].b = third(e0_q.b, e1_q.b);
      job_o.pal[3].r = third(e1_q.r, e0_q.r);
      job_o.pal[3].g = third(e1_q.g, e0_q.g);
      job_o.pal[3].b = third(e1_q.b, e0_q.b);
    end else begin
      job_o.pal[2].r = sum_r[8:1];
      job_o.pal[2].g = sum_g[8:1];
      job_o.pal[2].b = sum_b[8:1];
      job_o.pal[3]   = '0;
    end
    job_o.atab[0] = a0;
    job_o.atab[1] = a1;
    for (int i = 2; i < 8; i++) begin
      if (a0 > a1) begin
        ap = 22'(a0) * 22'((8 - i) * DIV7_K) + 22'(a1) * 22'((i - 1) * DIV7_K);
        job_o.atab[i] = ap[21:14];
      end else if (i < 6) begin
        ap = 22'(a0) * 22'((6 - i) * DIV5_K) + 22'(a1) * 22'((i - 1) * DIV5_K);
        job_o.atab[i] = ap[21:14];
      end else begin
        job_o.atab[i] = (i == 6) ? 8'd0 : 8'd255;
      end
    end
    job_o.cidx = cidx_q;
    job_o.ablk = ablk_q;
    job_o.col  = col_q;
    job_o.row  = row_q;
    job_o.mask = mask_q;
  end

endmodule

// ===== src/dxt_fifo.sv =====
module dxt_fifo #(
  parameter int DEPTH = dxt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          push_ready_o,
  input  dxt_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output dxt_pkg::job_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dxt_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CNT_FULL;
  assign valid_o      = count_q != '0;
  assign data_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_FULL)
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count lost on pop");

endmodule

// ===== src/dxt_back.sv =====
module dxt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  dxt_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [11:0]   texel_x_o,
  output logic [11:0]   texel_y_o,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o,
  output logic [7:0]    alpha_o,
  output logic          last_o
);

  dxt_pkg::job_t cur_q;
  logic          cur_valid_q, cur_valid_d;
  logic [15:0]   rem_q, rem_d, rem_clr;
  logic [3:0]    sel;
  logic          emit, done, cur_free, load;
  logic [1:0]    cidx [16];
  logic [2:0]    aidx [16];
  logic [3:0]    anib [16];
  logic [1:0]    ci;
  dxt_pkg::rgb_t col;
  logic [7:0]    alpha_d;

  logic          out_valid_q;
  logic [11:0]   x_q, y_q;
  logic [7:0]    r_q, g_q, b_q, a_q;
  logic          last_q;

  // lowest texel still to send
  always_comb begin
    sel = '0;
    for (int k = 15; k >= 0; k--) begin
      if (rem_q[k]) begin
        sel = 4'(k);
      end
    end
  end

  assign rem_clr  = rem_q & ~(16'd1 << sel);
  assign emit     = cur_valid_q && (!out_valid_q || out_ready_i);
  assign done     = emit && (rem_clr == '0);
  assign cur_free = !cur_valid_q || done;
  assign pop_o    = head_valid_i && ((head_i.mask == '0) || cur_free);
  assign load     = head_valid_i && (head_i.mask != '0) && cur_free;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      cidx[k] = cur_q.cidx[2*k +: 2];
      aidx[k] = cur_q.ablk[16 + 3*k +: 3];
      anib[k] = cur_q.ablk[4*k +: 4];
    end
  end

  assign ci  = cidx[sel];
  assign col = cur_q.pal[ci];

  always_comb begin
    unique case (cur_q.fmt)
      dxt_pkg::FMT_DXT3: alpha_d = {anib[sel], anib[sel]};
      dxt_pkg::FMT_DXT5: alpha_d = cur_q.atab[aidx[sel]];
      default:           alpha_d = (ci == 2'd3 && !cur_q.four) ? 8'd0 : 8'd255;
    endcase
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    rem_d       = rem_q;
    if (load) begin
      cur_valid_d = 1'b1;
      rem_d       = head_i.mask;
    end else if (done) begin
      cur_valid_d = 1'b0;
      rem_d       = '0;
    end else if (emit) begin
      rem_d = rem_clr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      rem_q       <= rem_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= head_i;
    end
    if (emit) begin
      x_q    <= {cur_q.col, sel[1:0]};
      y_q    <= {cur_q.row, sel[3:2]};
      r_q    <= col.r;
      g_q    <= col.g;
      b_q    <= col.b;
      a_q    <= alpha_d;
      last_q <= rem_clr == '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign texel_x_o   = x_q;
  assign texel_y_o   = y_q;
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;
  assign alpha_o     = a_q;
  assign last_o      = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_valid_q |-> rem_q != '0)
    else $error("active block with no texels left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && (rem_clr != '0) |=> cur_valid_q && !$past(load))
    else $error("block dropped before its last texel");

  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |=> out_valid_q)
    else $error("emitted texel not presented");

endmodule

// ===== src/dxt_block_texel_decoder.sv =====
// S3TC block decoder for DXT1, DXT3 and DXT5. A request carries one 4x4 block (colour and
// alpha halves) and its block column and row; the result channel delivers one RGBA texel per
// cycle unless it is stalled, in raster order inside the block, texels outside the configured
// image are dropped and the final texel of a block has last set. A front end widens the
// endpoints and builds the palette and alpha table, then hands the block to a small queue, so
// a new request is taken every cycle while the queue has room. The back end sends one texel per
// cycle unless the result channel stalls; a block sends its texels inside the image (all 16
// for an interior block) and one with none sends nothing. Registers: 0x0 format (0 DXT1,
// 1 DXT3, 2 DXT5, 3 as DXT1), 0x4 image width, 0x8 image height (reset 4096); change them
// only while no block is in flight.
module dxt_block_texel_decoder #(
  parameter int MAX_DIM     = dxt_pkg::MAX_DIM_DEF,
  parameter int QUEUE_DEPTH = dxt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] color_block_i,
  input  logic [63:0] alpha_block_i,
  input  logic [9:0]  block_col_i,
  input  logic [9:0]  block_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] texel_x_o,
  output logic [11:0] texel_y_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_o
);

  logic [1:0]    fmt_q, fmt_d;
  logic [12:0]   width_q, width_d, height_q, height_d;
  logic          wr;
  dxt_pkg::cfg_t cfg;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    fmt_d    = fmt_q;
    width_d  = width_q;
    height_d = height_q;
    if (wr) begin
      unique case (paddr[3:2])
        dxt_pkg::REG_FORMAT: fmt_d    = pwdata[1:0];
        dxt_pkg::REG_WIDTH:  width_d  = pwdata[12:0];
        dxt_pkg::REG_HEIGHT: height_d = pwdata[12:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= dxt_pkg::FMT_DXT1;
      width_q  <= 13'd4096;
      height_q <= 13'd4096;
    end else begin
      fmt_q    <= fmt_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dxt_pkg::REG_FORMAT: prdata = {30'd0, fmt_q};
      dxt_pkg::REG_WIDTH:  prdata = {19'd0, width_q};
      dxt_pkg::REG_HEIGHT: prdata = {19'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg.fmt    = fmt_q;
  assign cfg.width  = width_q;
  assign cfg.height = height_q;

  logic          push, push_ready, head_valid, pop;
  dxt_pkg::job_t job, head;

  dxt_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .color_block_i (color_block_i),
    .alpha_block_i (alpha_block_i),
    .block_col_i   (block_col_i),
    .block_row_i   (block_row_i),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .job_o         (job)
  );

  dxt_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .data_i       (job),
    .pop_i        (pop),
    .valid_o      (head_valid),
    .data_o       (head)
  );

  dxt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .texel_x_o    (texel_x_o),
    .texel_y_o    (texel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .last_o       (last_o)
  );

endmodule
